### rtl/core/waypoint_loop_interpolator_unit_assert.svh
// Assertion macros for the waypoint loop interpolator.
`ifndef WAYPOINT_LOOP_INTERPOLATOR_UNIT_ASSERT_SVH
`define WAYPOINT_LOOP_INTERPOLATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WLINT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define WLINT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/wlint_pkg.sv
// Shared types and constants for the waypoint loop interpolator.
package wlint_pkg;

  localparam int unsigned MAX_POINTS_DEFAULT = 64;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned SPEED_FRAC_W = 8;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned SEG_W = 6;
  localparam int unsigned REQ_W = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_W = 112;

  localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd512;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_TICK  = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_HELD = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED    = 1'b0,
    REG_PLAYBACK = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INC,
    S_MOD,
    S_RDA,
    S_RDB,
    S_MUL,
    S_ADD,
    S_OUT
  } fsm_t;

  typedef struct packed {
    logic wr;
    logic cap_a;
    logic mul;
    logic upd;
  } lane_ctl_t;

endpackage

### rtl/core/waypoint_loop_interpolator_unit.sv
// Top level of the waypoint loop interpolator: control, phase update and result merge.
//
//  Channel   Direction  Beat contents
//  s_*       in         tuser: req_type; tdata: point_x, point_y, point_z, delta_time
//  m_*       out        tdata: pos_x, pos_y, pos_z, point_count, segment_index, status
//  cfg_*     in         register index and data, one write per cycle with cfg_we
//
// Add, clear and non-advancing ticks go from accept straight to the output state. An advancing
// tick first passes the increment, remainder, lane read A and B, multiply and add states; the remainder
// unit that wraps the phase settles one quotient bit per cycle.
// The next beat is taken once the result is loaded, even while that result still waits.
// Reset is synchronous; the waypoint stores are not cleared, but the count, phase and held positions are.
module waypoint_loop_interpolator_unit
  import wlint_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [IN_W-1:0]                        s_tdata,  // point_x, point_y, point_z, delta_time
  input  logic [REQ_W-1:0]                       s_tuser,  // req_type
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // pos_x, pos_y, pos_z, point_count, segment_index, status
  output logic [((3*COORD_W+$clog2(MAX_POINTS+1)+SEG_W+STATUS_W+7)/8)*8-1:0] m_tdata,
  input  logic                                   cfg_we,
  input  logic [CFG_IDX_W-1:0]                   cfg_index,
  input  logic [CFG_DATA_W-1:0]                  cfg_data
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned PH_W = IDX_W + FRAC_W;
  localparam int unsigned INC_W = TIME_W + SPEED_W - SPEED_FRAC_W;
  localparam int unsigned SUM_W = ((PH_W > INC_W) ? PH_W : INC_W) + 1;
  localparam int unsigned SPAN_W = CNT_W + FRAC_W;
  localparam int unsigned K_MAX = SUM_W - 18;
  localparam int unsigned OUT_BITS = 3 * COORD_W + CNT_W + SEG_W + STATUS_W;
  localparam int unsigned OUT_W = ((OUT_BITS + 7) / 8) * 8;

  fsm_t                  state;
  fsm_t                  state_next;
  logic [CNT_W-1:0]      count;
  logic [PH_W-1:0]       phase;
  logic [SPEED_W-1:0]    speed;
  logic                  playback;
  logic [TIME_W-1:0]     dt_r;
  logic [STATUS_W-1:0]   status_r;

  logic                  accept;
  logic                  out_free;
  logic                  has_room;
  logic                  can_run;
  logic [COORD_W-1:0]    in_x;
  logic [COORD_W-1:0]    in_y;
  logic [COORD_W-1:0]    in_z;
  logic [TIME_W-1:0]     in_dt;

  logic [TIME_W+SPEED_W-1:0] step_prod;
  logic [SUM_W-1:0]      dividend;
  logic                  mod_start;
  logic                  mod_busy;
  logic [SPAN_W-1:0]     mod_rem;

  logic [IDX_W-1:0]      idx_raw;
  logic [IDX_W-1:0]      idx;
  logic [CNT_W-1:0]      nxt_wide;
  logic [IDX_W-1:0]      nxt;
  logic [IDX_W-1:0]      raddr;
  logic [IDX_W+SEG_W-1:0] seg_wide;
  lane_ctl_t             ctl;
  logic [COORD_W-1:0]    pos_x;
  logic [COORD_W-1:0]    pos_y;
  logic [COORD_W-1:0]    pos_z;

  assign in_x  = s_tdata[COORD_W-1:0];
  assign in_y  = s_tdata[2*COORD_W-1:COORD_W];
  assign in_z  = s_tdata[3*COORD_W-1:2*COORD_W];
  assign in_dt = s_tdata[3*COORD_W+TIME_W-1:3*COORD_W];

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign has_room = count < CNT_W'(MAX_POINTS);
  assign can_run  = playback && (count >= CNT_W'(2));

  assign step_prod = dt_r * speed;
  assign dividend  = SUM_W'(phase) + SUM_W'(step_prod[TIME_W+SPEED_W-1:SPEED_FRAC_W]);

  assign idx_raw  = phase[PH_W-1:FRAC_W];
  assign idx      = (CNT_W'(idx_raw) >= count) ? '0 : idx_raw;
  assign nxt_wide = CNT_W'(idx) + 1'b1;
  assign nxt      = (nxt_wide >= count) ? '0 : nxt_wide[IDX_W-1:0];
  assign seg_wide = (IDX_W + SEG_W)'(idx_raw);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (s_tuser == REQ_TICK && can_run) begin
            state_next = S_INC;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_INC: state_next = S_MOD;
      S_MOD: begin
        if (!mod_busy) begin
          state_next = S_RDA;
        end
      end
      S_RDA: state_next = S_RDB;
      S_RDB: state_next = S_MUL;
      S_MUL: state_next = S_ADD;
      S_ADD: state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == S_IDLE) && !rst;
    mod_start = (state == S_INC);
    ctl.wr    = accept && (s_tuser == REQ_ADD) && has_room;
    ctl.cap_a = (state == S_RDB);
    ctl.mul   = (state == S_MUL);
    ctl.upd   = (state == S_ADD);
    raddr     = (state == S_RDA) ? idx : nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      phase    <= '0;
      speed    <= SPEED_RESET;
      playback <= 1'b0;
      status_r <= STAT_OK;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_SPEED:    speed <= cfg_data[SPEED_W-1:0];
          REG_PLAYBACK: playback <= cfg_data[0];
          default:      ;
        endcase
      end
      if (accept) begin
        case (s_tuser)
          REQ_ADD: begin
            if (has_room) begin
              count    <= count + 1'b1;
              status_r <= STAT_OK;
            end else begin
              status_r <= STAT_FULL;
            end
          end
          REQ_CLEAR: begin
            count    <= '0;
            phase    <= '0;
            status_r <= STAT_OK;
          end
          REQ_TICK: begin
            status_r <= (playback && !can_run) ? STAT_HELD : STAT_OK;
          end
          default: status_r <= STAT_OK;
        endcase
      end
      if (state == S_MOD && !mod_busy) begin
        phase <= mod_rem[PH_W-1:0];
      end
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dt_r <= in_dt;
    end
    if (state == S_OUT && out_free) begin
      m_tdata <= OUT_W'({status_r, seg_wide[SEG_W-1:0], count, pos_z, pos_y, pos_x});
    end
  end

  wlint_mod #(
    .DIV_W (SUM_W),
    .SPAN_W(SPAN_W),
    .K_MAX (K_MAX)
  ) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .dividend(dividend),
    .span    ({count, {FRAC_W{1'b0}}}),
    .busy    (mod_busy),
    .rem     (mod_rem)
  );

  wlint_lane #(.DEPTH(MAX_POINTS)) u_lane_x (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .waddr(count[IDX_W-1:0]),
    .wdata(in_x),
    .raddr(raddr),
    .t    (phase[FRAC_W-1:0]),
    .pos  (pos_x)
  );

  wlint_lane #(.DEPTH(MAX_POINTS)) u_lane_y (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .waddr(count[IDX_W-1:0]),
    .wdata(in_y),
    .raddr(raddr),
    .t    (phase[FRAC_W-1:0]),
    .pos  (pos_y)
  );

  wlint_lane #(.DEPTH(MAX_POINTS)) u_lane_z (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .waddr(count[IDX_W-1:0]),
    .wdata(in_z),
    .raddr(raddr),
    .t    (phase[FRAC_W-1:0]),
    .pos  (pos_z)
  );

`include "waypoint_loop_interpolator_unit_assert.svh"

  `WLINT_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(MAX_POINTS), "point count past table size")
  `WLINT_ASSERT_NOW(a_phase_idle, count < CNT_W'(2), phase == '0, "phase not zero with under two points")
  `WLINT_ASSERT_NEXT(a_full_flag, accept && s_tuser == REQ_ADD && !has_room, status_r == STAT_FULL && $stable(count), "dropped add not flagged")
  `WLINT_ASSERT_NOW(a_lane_order, state == S_RDA || state == S_RDB || state == S_MUL, !mod_busy && !accept, "lane read overlaps remainder or accept")

endmodule

### rtl/core/wlint_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wlint_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/wlint_mod.sv
// Restoring remainder unit that settles one quotient bit per cycle.
module wlint_mod #(
  parameter int unsigned DIV_W  = 25,
  parameter int unsigned SPAN_W = 23,
  parameter int unsigned K_MAX  = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [SPAN_W-1:0] span,
  output logic              busy,
  output logic [SPAN_W-1:0] rem
);

  localparam int unsigned CW = SPAN_W + K_MAX;
  localparam int unsigned RW = (DIV_W > CW) ? DIV_W : CW;
  localparam int unsigned KC_W = $clog2(K_MAX + 1);

  logic [RW-1:0]   rem_r;
  logic [RW-1:0]   div_r;
  logic [KC_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= KC_W'(K_MAX);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= RW'(dividend);
      div_r <= RW'(span) << K_MAX;
    end else if (busy) begin
      if (rem_r >= div_r) begin
        rem_r <= rem_r - div_r;
      end
      div_r <= div_r >> 1;
    end
  end

  assign rem = rem_r[SPAN_W-1:0];

endmodule

### rtl/core/wlint_lane.sv
// One coordinate lane: waypoint store, segment blend and held position.
module wlint_lane
  import wlint_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_POINTS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lane_ctl_t                ctl,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [COORD_W-1:0]       wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  input  logic [FRAC_W-1:0]        t,
  output logic [COORD_W-1:0]       pos
);

  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned PROD_W = DIFF_W + FRAC_W + 1;
  localparam int unsigned Q_W = PROD_W - FRAC_W;

  logic [COORD_W-1:0]       rdata;
  logic [COORD_W-1:0]       a_r;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [Q_W-1:0]    q;
  logic [Q_W-1:0]           sum;

  wlint_ram #(
    .WIDTH(COORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ctl.wr),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign diff = $signed({rdata[COORD_W-1], rdata}) - $signed({a_r[COORD_W-1], a_r});
  assign prod = diff * $signed({1'b0, t});
  assign q    = prod_r[PROD_W-1:FRAC_W];
  assign sum  = {{(Q_W-COORD_W){a_r[COORD_W-1]}}, a_r} + q;

  always_ff @(posedge clk) begin
    if (ctl.cap_a) begin
      a_r <= rdata;
    end
    if (ctl.mul) begin
      prod_r <= prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (ctl.upd) begin
      pos <= sum[COORD_W-1:0];
    end
  end

endmodule
